// File: rtl/assert_macros.svh
// assertion helpers, clocked on clk and held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SPG_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/spg_pkg.sv
package spg_pkg;

    localparam int MAX_GRID     = 64;
    localparam int MAX_BORDER   = 4;
    localparam int FRAC_BITS    = 16;

    localparam int COMP_W       = 20;
    localparam int VEC_W        = 3 * COMP_W;
    localparam int IDX_W        = 7;
    localparam int GRID_W       = 7;
    localparam int BORD_W       = 3;
    localparam int BCLAMP_W     = 4;
    localparam int COEF_W       = 9;
    localparam int OFF_W        = 14;
    localparam int OUT_W        = 18;
    localparam int CFG_IDX_W    = 3;

    localparam int PROD_W       = 29;
    localparam int P_W          = 30;
    localparam int MAG_W        = 29;
    localparam int NORM_BIT     = 27;
    localparam int SH_W         = $clog2(NORM_BIT + 1);
    localparam int SQ_W         = 2 * MAG_W + 2;
    localparam int ROOT_W       = SQ_W / 2;
    localparam int REM_W        = ROOT_W + 2;
    localparam int QB           = FRAC_BITS + 1;
    localparam int DIV_W        = MAG_W + FRAC_BITS + 1;

    localparam int Q_DEPTH      = 2;
    localparam int Q_PTR_W      = 1;
    localparam int Q_CNT_W      = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER  = 3'd0,
        CFG_SPAN_U  = 3'd1,
        CFG_SPAN_V  = 3'd2,
        CFG_GRID    = 3'd3,
        CFG_BORDER  = 3'd4,
        CFG_REVERSE = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic [GRID_W-1:0]        g;
        logic [OFF_W-1:0]         offset;
    } pt_item_t;

endpackage

// File: rtl/spg_front.sv
module spg_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [spg_pkg::IDX_W-1:0]    row,
    input  logic [spg_pkg::IDX_W-1:0]    col,
    input  logic [spg_pkg::GRID_W-1:0]   grid_size,
    input  logic [spg_pkg::BORD_W-1:0]   border_width,
    input  logic                         reverse_rows,
    output logic                         out_valid,
    input  logic                         out_ready,
    output spg_pkg::pt_item_t            out_item
);

    logic                              vld_reg;
    spg_pkg::pt_item_t                 item_reg;
    spg_pkg::pt_item_t                 item_next;
    logic [spg_pkg::GRID_W-1:0]        g_c;
    logic [spg_pkg::BCLAMP_W-1:0]      bw_c;
    logic [spg_pkg::GRID_W-2:0]        half_c;
    logic [spg_pkg::GRID_W-1:0]        gs_c;
    logic [spg_pkg::OFF_W-1:0]         rpos_c;
    logic [spg_pkg::OFF_W-1:0]         lin_c;
    logic [spg_pkg::OFF_W-1:0]         cell_c;

    always_comb
    begin
        if (grid_size == '0)
            g_c = spg_pkg::GRID_W'(1);
        else if (grid_size > spg_pkg::GRID_W'(spg_pkg::MAX_GRID))
            g_c = spg_pkg::GRID_W'(spg_pkg::MAX_GRID);
        else
            g_c = grid_size;
        if ({1'b0, border_width} > spg_pkg::BCLAMP_W'(spg_pkg::MAX_BORDER))
            bw_c = spg_pkg::BCLAMP_W'(spg_pkg::MAX_BORDER);
        else
            bw_c = {1'b0, border_width};
        half_c = g_c[spg_pkg::GRID_W-1:1];
        gs_c = g_c + spg_pkg::GRID_W'(1) + spg_pkg::GRID_W'({bw_c, 1'b0});

        // signed coefficients, exact in nine bits for every index
        item_next.a = $signed(spg_pkg::COEF_W'(col) - spg_pkg::COEF_W'(bw_c)
                              - spg_pkg::COEF_W'(half_c));
        item_next.b = $signed(spg_pkg::COEF_W'(half_c) + spg_pkg::COEF_W'(bw_c)
                              - spg_pkg::COEF_W'(row));
        item_next.g = g_c;

        // mirrored row wraps modulo the offset width
        if (reverse_rows)
            rpos_c = spg_pkg::OFF_W'(gs_c) - spg_pkg::OFF_W'(1) - spg_pkg::OFF_W'(row);
        else
            rpos_c = spg_pkg::OFF_W'(row);
        lin_c = rpos_c * spg_pkg::OFF_W'(gs_c);
        cell_c = lin_c + spg_pkg::OFF_W'(col);
        item_next.offset = cell_c + (cell_c << 1);
    end

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// File: rtl/spg_queue.sv
`include "assert_macros.svh"

module spg_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  spg_pkg::pt_item_t in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output spg_pkg::pt_item_t out_item
);

    spg_pkg::pt_item_t               mem [spg_pkg::Q_DEPTH];
    logic [spg_pkg::Q_PTR_W-1:0]     wr_ptr_reg;
    logic [spg_pkg::Q_PTR_W-1:0]     rd_ptr_reg;
    logic [spg_pkg::Q_CNT_W-1:0]     count_reg;
    logic [spg_pkg::Q_CNT_W-1:0]     count_next;
    logic                            push;
    logic                            pop;

    assign in_ready  = count_reg != spg_pkg::Q_CNT_W'(spg_pkg::Q_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + spg_pkg::Q_CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - spg_pkg::Q_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == spg_pkg::Q_PTR_W'(spg_pkg::Q_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + spg_pkg::Q_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == spg_pkg::Q_PTR_W'(spg_pkg::Q_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + spg_pkg::Q_PTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= in_item;
    end

    `SPG_ASSERT_IMPLY(a_q_count_max, 1'b1, count_reg <= spg_pkg::Q_CNT_W'(spg_pkg::Q_DEPTH), "queue overfilled")
    `SPG_ASSERT_NEXT(a_q_pass, push && pop, $stable(count_reg), "queue count moved on push and pop")

endmodule

// File: rtl/spg_back.sv
`include "assert_macros.svh"

module spg_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [spg_pkg::VEC_W-1:0]          center_vec,
    input  logic [spg_pkg::VEC_W-1:0]          span_u_vec,
    input  logic [spg_pkg::VEC_W-1:0]          span_v_vec,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  spg_pkg::pt_item_t                  in_item,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [spg_pkg::OUT_W-1:0]   unit_x,
    output logic signed [spg_pkg::OUT_W-1:0]   unit_y,
    output logic signed [spg_pkg::OUT_W-1:0]   unit_z,
    output logic [spg_pkg::OFF_W-1:0]          mesh_offset,
    output logic                               zero_length
);

    localparam int DEPTH = 9 + spg_pkg::ROOT_W + spg_pkg::QB;

    typedef struct packed {
        logic [2:0][spg_pkg::MAG_W-1:0] mag;
        logic [2:0]                     neg;
        logic                           zero;
        logic [spg_pkg::OFF_W-1:0]      offset;
    } carry_t;

    typedef struct packed {
        logic [2:0]                     neg;
        logic                           zero;
        logic [spg_pkg::OFF_W-1:0]      offset;
    } tag_t;

    logic                              en;
    logic [DEPTH-1:0]                  vld_reg;

    // stage 1: products
    logic signed [spg_pkg::PROD_W-1:0] pc_reg [3];
    logic signed [spg_pkg::PROD_W-1:0] pu_reg [3];
    logic signed [spg_pkg::PROD_W-1:0] pv_reg [3];
    logic [spg_pkg::OFF_W-1:0]         off1_reg;
    // stage 2: sign and magnitude
    carry_t                            cy2_reg;
    carry_t                            cy2_next;
    logic signed [spg_pkg::P_W-1:0]    p_c [3];
    // stage 3: largest magnitude
    carry_t                            cy3_reg;
    logic [spg_pkg::MAG_W-1:0]         m3_reg;
    logic [spg_pkg::MAG_W-1:0]         m_c;
    // stage 4: shift count
    carry_t                            cy4_reg;
    carry_t                            cy4_next;
    logic [spg_pkg::SH_W-1:0]          sh4_reg;
    logic [spg_pkg::SH_W-1:0]          sh_c;
    // stage 5: normalized magnitudes
    carry_t                            cy5_reg;
    carry_t                            cy5_next;
    // stage 6: squares
    carry_t                            cy6_reg;
    logic [spg_pkg::SQ_W-1:0]          sq6_reg [3];
    // stage 7: sum of squares
    carry_t                            cy7_reg;
    logic [spg_pkg::SQ_W-1:0]          s7_reg;
    // square root stages
    logic [spg_pkg::REM_W-1:0]         rt_rem_reg  [spg_pkg::ROOT_W];
    logic [spg_pkg::ROOT_W-1:0]        rt_root_reg [spg_pkg::ROOT_W];
    logic [spg_pkg::SQ_W-1:0]          rt_s_reg    [spg_pkg::ROOT_W];
    carry_t                            rt_cy_reg   [spg_pkg::ROOT_W];
    // dividend stage
    logic [spg_pkg::DIV_W-1:0]         n_reg [3];
    logic [spg_pkg::ROOT_W-1:0]        l_reg;
    tag_t                              tag_n_reg;
    // divider stages
    logic [spg_pkg::DIV_W-1:0]         dv_rem_reg [spg_pkg::QB][3];
    logic [spg_pkg::QB-1:0]            dv_q_reg   [spg_pkg::QB][3];
    logic [spg_pkg::ROOT_W-1:0]        dv_l_reg   [spg_pkg::QB];
    tag_t                              dv_tag_reg [spg_pkg::QB];
    // result
    logic signed [spg_pkg::OUT_W-1:0]  res_reg [3];
    logic [spg_pkg::OFF_W-1:0]         off_out_reg;
    logic                              zero_out_reg;
    logic signed [spg_pkg::OUT_W-1:0]  res_next [3];

    assign out_valid = vld_reg[DEPTH-1];
    assign en        = !out_valid || out_ready;
    assign in_ready  = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
        end
    end

    always_comb
    begin
        cy2_next.zero = 1'b0;
        cy2_next.offset = off1_reg;
        for (int k = 0; k < 3; k++)
        begin
            p_c[k] = pc_reg[k] + pu_reg[k] + pv_reg[k];
            cy2_next.neg[k] = p_c[k][spg_pkg::P_W-1];
            cy2_next.mag[k] = p_c[k][spg_pkg::P_W-1] ? spg_pkg::MAG_W'(-p_c[k]) :
                                                       spg_pkg::MAG_W'(p_c[k]);
        end
    end

    always_comb
    begin
        m_c = cy2_reg.mag[0];
        if (cy2_reg.mag[1] > m_c)
            m_c = cy2_reg.mag[1];
        if (cy2_reg.mag[2] > m_c)
            m_c = cy2_reg.mag[2];
    end

    // distance of the leading one below the normalization bit
    always_comb
    begin
        sh_c = '0;
        for (int i = 0; i < spg_pkg::NORM_BIT; i++)
        begin
            if (m3_reg[i])
                sh_c = spg_pkg::SH_W'(spg_pkg::NORM_BIT - i);
        end
        if (|m3_reg[spg_pkg::MAG_W-1:spg_pkg::NORM_BIT])
            sh_c = '0;
    end

    always_comb
    begin
        cy4_next      = cy3_reg;
        cy4_next.zero = m3_reg == '0;
        cy5_next      = cy4_reg;
        for (int k = 0; k < 3; k++)
            cy5_next.mag[k] = cy4_reg.mag[k] << sh4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pc_reg[k] <= $signed(center_vec[k*spg_pkg::COMP_W +: spg_pkg::COMP_W])
                             * $signed({1'b0, in_item.g});
                pu_reg[k] <= $signed(span_u_vec[k*spg_pkg::COMP_W +: spg_pkg::COMP_W])
                             * in_item.a;
                pv_reg[k] <= $signed(span_v_vec[k*spg_pkg::COMP_W +: spg_pkg::COMP_W])
                             * in_item.b;
            end
            off1_reg <= in_item.offset;

            cy2_reg <= cy2_next;

            cy3_reg <= cy2_reg;
            m3_reg  <= m_c;

            cy4_reg <= cy4_next;
            sh4_reg <= sh_c;

            cy5_reg <= cy5_next;

            // normalized magnitudes stay below 2^28
            cy6_reg <= cy5_reg;
            for (int k = 0; k < 3; k++)
                sq6_reg[k] <= spg_pkg::SQ_W'(cy5_reg.mag[k][spg_pkg::NORM_BIT:0]
                                             * cy5_reg.mag[k][spg_pkg::NORM_BIT:0]);

            cy7_reg <= cy6_reg;
            s7_reg  <= sq6_reg[0] + sq6_reg[1] + sq6_reg[2];
        end
    end

    // digit-by-digit square root, one root bit per stage
    for (genvar j = 0; j < spg_pkg::ROOT_W; j++)
    begin : g_sqrt
        localparam int BIT = spg_pkg::ROOT_W - 1 - j;
        logic [spg_pkg::REM_W-1:0]  rem_in;
        logic [spg_pkg::ROOT_W-1:0] root_in;
        logic [spg_pkg::SQ_W-1:0]   s_in;
        carry_t                     cy_in;
        logic [spg_pkg::REM_W-1:0]  rem_x;
        logic [spg_pkg::REM_W-1:0]  trial;
        logic                       ge;

        if (j == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign s_in    = s7_reg;
            assign cy_in   = cy7_reg;
        end
        else
        begin : g_rest
            assign rem_in  = rt_rem_reg[j-1];
            assign root_in = rt_root_reg[j-1];
            assign s_in    = rt_s_reg[j-1];
            assign cy_in   = rt_cy_reg[j-1];
        end

        assign rem_x = {rem_in[spg_pkg::REM_W-3:0], s_in[2*BIT+1 -: 2]};
        assign trial = {root_in, 2'b01};
        assign ge    = rem_x >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rt_rem_reg[j]  <= ge ? rem_x - trial : rem_x;
                rt_root_reg[j] <= {root_in[spg_pkg::ROOT_W-2:0], ge};
                rt_s_reg[j]    <= s_in;
                rt_cy_reg[j]   <= cy_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
                n_reg[k] <= (spg_pkg::DIV_W'(rt_cy_reg[spg_pkg::ROOT_W-1].mag[k])
                             << spg_pkg::FRAC_BITS)
                            + spg_pkg::DIV_W'(rt_root_reg[spg_pkg::ROOT_W-1] >> 1);
            l_reg            <= rt_root_reg[spg_pkg::ROOT_W-1];
            tag_n_reg.neg    <= rt_cy_reg[spg_pkg::ROOT_W-1].neg;
            tag_n_reg.zero   <= rt_cy_reg[spg_pkg::ROOT_W-1].zero;
            tag_n_reg.offset <= rt_cy_reg[spg_pkg::ROOT_W-1].offset;
        end
    end

    // restoring division, one quotient bit per stage for all three components
    for (genvar j = 0; j < spg_pkg::QB; j++)
    begin : g_div
        localparam int BIT = spg_pkg::QB - 1 - j;
        logic [spg_pkg::DIV_W-1:0]  rem_in [3];
        logic [spg_pkg::QB-1:0]     q_in   [3];
        logic [spg_pkg::ROOT_W-1:0] l_in;
        tag_t                       tag_in;
        logic [spg_pkg::DIV_W-1:0]  dsr;

        if (j == 0)
        begin : g_first
            for (genvar k = 0; k < 3; k++)
            begin : g_k
                assign rem_in[k] = n_reg[k];
                assign q_in[k]   = '0;
            end
            assign l_in   = l_reg;
            assign tag_in = tag_n_reg;
        end
        else
        begin : g_rest
            for (genvar k = 0; k < 3; k++)
            begin : g_k
                assign rem_in[k] = dv_rem_reg[j-1][k];
                assign q_in[k]   = dv_q_reg[j-1][k];
            end
            assign l_in   = dv_l_reg[j-1];
            assign tag_in = dv_tag_reg[j-1];
        end

        assign dsr = spg_pkg::DIV_W'(l_in) << BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    dv_rem_reg[j][k] <= (rem_in[k] >= dsr) ? rem_in[k] - dsr : rem_in[k];
                    dv_q_reg[j][k]   <= {q_in[k][spg_pkg::QB-2:0], rem_in[k] >= dsr};
                end
                dv_l_reg[j]   <= l_in;
                dv_tag_reg[j] <= tag_in;
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (dv_tag_reg[spg_pkg::QB-1].zero)
                res_next[k] = '0;
            else if (dv_tag_reg[spg_pkg::QB-1].neg[k])
                res_next[k] = -$signed(spg_pkg::OUT_W'(dv_q_reg[spg_pkg::QB-1][k]));
            else
                res_next[k] = $signed(spg_pkg::OUT_W'(dv_q_reg[spg_pkg::QB-1][k]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
                res_reg[k] <= res_next[k];
            off_out_reg  <= dv_tag_reg[spg_pkg::QB-1].offset;
            zero_out_reg <= dv_tag_reg[spg_pkg::QB-1].zero;
        end
    end

    assign unit_x      = res_reg[0];
    assign unit_y      = res_reg[1];
    assign unit_z      = res_reg[2];
    assign mesh_offset = off_out_reg;
    assign zero_length = zero_out_reg;

    `SPG_ASSERT_IMPLY(a_zero_unit, out_valid && zero_length,
                      unit_x == '0 && unit_y == '0 && unit_z == '0,
                      "zero point with nonzero unit vector")
    `SPG_ASSERT_IMPLY(a_idle_ready, !out_valid, in_ready,
                      "back end stalled without a waiting result")

endmodule

// File: rtl/sphere_patch_grid_point_unit.sv
// channel   direction  handshake                 payload
// in        input      in_valid / in_ready       row, col
// out       output     out_valid / out_ready     unit_x, unit_y, unit_z, mesh_offset, zero_length
// cfg       input      cfg_wr_en                 cfg_index, cfg_data
//
// one item per cycle sustained when the output never stalls
// most of the latency comes from the 30-stage square root and the 17-stage divider in the back end
// a two-entry queue between front and back keeps the front taking items while the back stalls, until it fills
// rst_n clears handshake state and loads the register reset values; no clearing pass

module sphere_patch_grid_point_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [spg_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [spg_pkg::VEC_W-1:0]            cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [spg_pkg::IDX_W-1:0]            row,
    input  logic [spg_pkg::IDX_W-1:0]            col,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [spg_pkg::OUT_W-1:0]     unit_x,
    output logic signed [spg_pkg::OUT_W-1:0]     unit_y,
    output logic signed [spg_pkg::OUT_W-1:0]     unit_z,
    output logic [spg_pkg::OFF_W-1:0]            mesh_offset,
    output logic                                 zero_length
);

    logic [spg_pkg::VEC_W-1:0]   center_vec_reg;
    logic [spg_pkg::VEC_W-1:0]   span_u_vec_reg;
    logic [spg_pkg::VEC_W-1:0]   span_v_vec_reg;
    logic [spg_pkg::GRID_W-1:0]  grid_size_reg;
    logic [spg_pkg::BORD_W-1:0]  border_width_reg;
    logic                        reverse_rows_reg;

    logic                        f_valid;
    logic                        f_ready;
    spg_pkg::pt_item_t           f_item;
    logic                        q_valid;
    logic                        q_ready;
    spg_pkg::pt_item_t           q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_vec_reg   <= '0;
            span_u_vec_reg   <= '0;
            span_v_vec_reg   <= '0;
            grid_size_reg    <= spg_pkg::GRID_W'(16);
            border_width_reg <= '0;
            reverse_rows_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (spg_pkg::cfg_idx_t'(cfg_index))
                spg_pkg::CFG_CENTER:  center_vec_reg   <= cfg_data;
                spg_pkg::CFG_SPAN_U:  span_u_vec_reg   <= cfg_data;
                spg_pkg::CFG_SPAN_V:  span_v_vec_reg   <= cfg_data;
                spg_pkg::CFG_GRID:    grid_size_reg    <= cfg_data[spg_pkg::GRID_W-1:0];
                spg_pkg::CFG_BORDER:  border_width_reg <= cfg_data[spg_pkg::BORD_W-1:0];
                spg_pkg::CFG_REVERSE: reverse_rows_reg <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    spg_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .row          (row),
        .col          (col),
        .grid_size    (grid_size_reg),
        .border_width (border_width_reg),
        .reverse_rows (reverse_rows_reg),
        .out_valid    (f_valid),
        .out_ready    (f_ready),
        .out_item     (f_item)
    );

    spg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    spg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .center_vec  (center_vec_reg),
        .span_u_vec  (span_u_vec_reg),
        .span_v_vec  (span_v_vec_reg),
        .in_valid    (q_valid),
        .in_ready    (q_ready),
        .in_item     (q_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .unit_x      (unit_x),
        .unit_y      (unit_y),
        .unit_z      (unit_z),
        .mesh_offset (mesh_offset),
        .zero_length (zero_length)
    );

endmodule

// File: tb/sv/sphere_patch_grid_point_unit_test.sv
module sphere_patch_grid_point_unit_test;

    // indexes past the register list, the block must ignore them
    localparam logic [spg_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [spg_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int MAX_SHOWN = 10;

    typedef struct {
        logic signed [spg_pkg::OUT_W-1:0] ux;
        logic signed [spg_pkg::OUT_W-1:0] uy;
        logic signed [spg_pkg::OUT_W-1:0] uz;
        logic [spg_pkg::OFF_W-1:0]        offset;
        logic                             zero;
    } vertex_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_wr_en;
    logic [spg_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [spg_pkg::VEC_W-1:0]        cfg_data;
    logic                             in_valid;
    logic                             in_ready;
    logic [spg_pkg::IDX_W-1:0]        row;
    logic [spg_pkg::IDX_W-1:0]        col;
    logic                             out_valid;
    logic                             out_ready;
    logic signed [spg_pkg::OUT_W-1:0] unit_x;
    logic signed [spg_pkg::OUT_W-1:0] unit_y;
    logic signed [spg_pkg::OUT_W-1:0] unit_z;
    logic [spg_pkg::OFF_W-1:0]        mesh_offset;
    logic                             zero_length;

    sphere_patch_grid_point_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .row(row), .col(col),
        .out_valid(out_valid), .out_ready(out_ready),
        .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
        .mesh_offset(mesh_offset), .zero_length(zero_length)
    );

    // shadow copy of the registers
    logic [spg_pkg::VEC_W-1:0]  center_reg;
    logic [spg_pkg::VEC_W-1:0]  span_u_reg;
    logic [spg_pkg::VEC_W-1:0]  span_v_reg;
    logic [spg_pkg::GRID_W-1:0] grid_reg;
    logic [spg_pkg::BORD_W-1:0] border_reg;
    logic                       reverse_reg;

    vertex_t pending_vertices[$];
    int      mismatches;
    bit      send_gaps;
    bit      ready_gaps;
    int      ready_hold;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic longint component(logic [spg_pkg::VEC_W-1:0] vec, int k);
        logic signed [spg_pkg::COMP_W-1:0] f;
        f = vec[spg_pkg::COMP_W*k +: spg_pkg::COMP_W];
        return f;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic vertex_t predict_vertex(logic [spg_pkg::IDX_W-1:0] r,
                                               logic [spg_pkg::IDX_W-1:0] c);
        longint g, bw, half, a, b, p;
        longint unsigned mag[3];
        longint unsigned m, s, l, q, gs, rpos, off;
        bit neg[3];
        logic [spg_pkg::OUT_W-1:0] unit[3];
        vertex_t v;
        g = grid_reg;
        bw = border_reg;
        if (g < 1) g = 1;
        if (g > spg_pkg::MAX_GRID) g = spg_pkg::MAX_GRID;
        if (bw > spg_pkg::MAX_BORDER) bw = spg_pkg::MAX_BORDER;
        half = g / 2;
        a = (longint'(c) - bw) - half;
        b = half - (longint'(r) - bw);
        m = 0;
        for (int k = 0; k < 3; k++)
        begin
            p = component(center_reg, k) * g + component(span_u_reg, k) * a
              + component(span_v_reg, k) * b;
            neg[k] = p < 0;
            mag[k] = neg[k] ? -p : p;
            if (mag[k] > m) m = mag[k];
        end
        if (m == 0)
        begin
            for (int k = 0; k < 3; k++) unit[k] = '0;
            v.zero = 1'b1;
        end
        else
        begin
            while (m < (64'd1 << spg_pkg::NORM_BIT))
            begin
                m <<= 1;
                for (int k = 0; k < 3; k++) mag[k] <<= 1;
            end
            s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
            l = int_sqrt(s);
            for (int k = 0; k < 3; k++)
            begin
                q = ((mag[k] << spg_pkg::FRAC_BITS) + (l >> 1)) / l;
                if (neg[k]) q = -q;
                unit[k] = q[spg_pkg::OUT_W-1:0];
            end
            v.zero = 1'b0;
        end
        v.ux = unit[0];
        v.uy = unit[1];
        v.uz = unit[2];
        gs = g + 1 + 2 * bw;
        rpos = reverse_reg ? gs - 1 - r : r;
        off = 3 * (rpos * gs + c);
        v.offset = off[spg_pkg::OFF_W-1:0];
        return v;
    endfunction

    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver side
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (ready_hold > 0)
        begin
            out_ready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end
        else if (ready_gaps)
            out_ready <= ($urandom_range(0, 99) < 70);
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        vertex_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_vertices.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected item: x=%0d y=%0d z=%0d off=%0d zero=%0b",
                             unit_x, unit_y, unit_z, mesh_offset, zero_length);
            end
            else
            begin
                want = pending_vertices.pop_front();
                if (unit_x !== want.ux || unit_y !== want.uy || unit_z !== want.uz
                    || mesh_offset !== want.offset || zero_length !== want.zero)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("mismatch: want %0d %0d %0d off=%0d z=%0b, got %0d %0d %0d off=%0d z=%0b",
                                 want.ux, want.uy, want.uz, want.offset, want.zero,
                                 unit_x, unit_y, unit_z, mesh_offset, zero_length);
                end
            end
        end
    end

    task automatic send_point(logic [spg_pkg::IDX_W-1:0] r, logic [spg_pkg::IDX_W-1:0] c);
        int gap;
        in_valid <= 1'b1;
        row <= r;
        col <= c;
        do
            @(posedge clk);
        while (!in_ready);
        pending_vertices.push_back(predict_vertex(r, c));
        gap = send_gaps ? gap_length() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        if (in_valid)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        while (pending_vertices.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    task automatic write_reg(logic [spg_pkg::CFG_IDX_W-1:0] idx,
                             logic [spg_pkg::VEC_W-1:0] data);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            spg_pkg::CFG_CENTER:  center_reg = data;
            spg_pkg::CFG_SPAN_U:  span_u_reg = data;
            spg_pkg::CFG_SPAN_V:  span_v_reg = data;
            spg_pkg::CFG_GRID:    grid_reg = data[spg_pkg::GRID_W-1:0];
            spg_pkg::CFG_BORDER:  border_reg = data[spg_pkg::BORD_W-1:0];
            spg_pkg::CFG_REVERSE: reverse_reg = data[0];
            default: ;
        endcase
    endtask

    function automatic logic [spg_pkg::VEC_W-1:0] random_vec();
        logic [spg_pkg::VEC_W-1:0] v;
        v = spg_pkg::VEC_W'({$urandom, $urandom});
        for (int k = 0; k < 3; k++)
            case ($urandom_range(0, 9))
                0: v[spg_pkg::COMP_W*k +: spg_pkg::COMP_W] = 20'h7FFFF;
                1: v[spg_pkg::COMP_W*k +: spg_pkg::COMP_W] = 20'h80000;
                2: v[spg_pkg::COMP_W*k +: spg_pkg::COMP_W] = '0;
                3: v[spg_pkg::COMP_W*k +: spg_pkg::COMP_W] =
                       spg_pkg::COMP_W'($urandom_range(0, 3) - 2);
                default: ;
            endcase
        return v;
    endfunction

    function automatic logic [spg_pkg::IDX_W-1:0] random_index();
        int span;
        span = (grid_reg > spg_pkg::MAX_GRID ? spg_pkg::MAX_GRID :
                (grid_reg == 0 ? 1 : grid_reg))
             + 1 + 2 * (border_reg > spg_pkg::MAX_BORDER ? spg_pkg::MAX_BORDER : border_reg);
        if ($urandom_range(0, 99) < 80)
            return spg_pkg::IDX_W'($urandom_range(0, span - 1));
        return spg_pkg::IDX_W'($urandom_range(0, 127));
    endfunction

    task automatic test_reset_values();
        send_point(0, 0);
        send_point(8, 8);
        send_point(16, 3);
        send_point(127, 127);
    endtask

    task automatic test_directed();
        write_reg(spg_pkg::CFG_CENTER, {20'h10000, 20'h00000, 20'h00000});
        write_reg(spg_pkg::CFG_SPAN_U, {20'h00000, 20'h00000, 20'h20000});
        write_reg(spg_pkg::CFG_SPAN_V, {20'h00000, 20'h20000, 20'h00000});
        write_reg(spg_pkg::CFG_GRID, 7'd1);
        write_reg(spg_pkg::CFG_BORDER, 3'd0);
        send_point(0, 0);
        send_point(1, 1);
        write_reg(spg_pkg::CFG_GRID, 7'd64);
        write_reg(spg_pkg::CFG_REVERSE, 1'b1);
        send_point(0, 0);
        send_point(64, 64);
        send_point(32, 32);
        // grid size zero and oversize border saturate
        write_reg(spg_pkg::CFG_GRID, 7'd0);
        write_reg(spg_pkg::CFG_BORDER, 3'd7);
        send_point(0, 127);
        send_point(127, 0);
        write_reg(spg_pkg::CFG_GRID, 7'd127);
        send_point(72, 72);
        send_point(127, 127);
        write_reg(spg_pkg::CFG_CENTER, {3{20'h7FFFF}});
        write_reg(spg_pkg::CFG_SPAN_U, {3{20'h80000}});
        write_reg(spg_pkg::CFG_SPAN_V, {3{20'h7FFFF}});
        write_reg(spg_pkg::CFG_REVERSE, 1'b0);
        write_reg(spg_pkg::CFG_BORDER, 3'd4);
        send_point(0, 0);
        send_point(127, 127);
        send_point(0, 127);
        // point exactly at the origin
        write_reg(spg_pkg::CFG_CENTER, '0);
        write_reg(spg_pkg::CFG_SPAN_V, '0);
        write_reg(spg_pkg::CFG_SPAN_U, {3{20'h00001}});
        write_reg(spg_pkg::CFG_GRID, 7'd16);
        write_reg(spg_pkg::CFG_BORDER, 3'd0);
        send_point(5, 8);
        send_point(5, 9);
        send_point(5, 7);
        write_reg(spg_pkg::CFG_REVERSE, 1'b1);
        send_point(127, 3);
    endtask

    task automatic test_spare_index();
        write_reg(CFG_SPARE_LO, spg_pkg::VEC_W'({$urandom, $urandom}));
        write_reg(CFG_SPARE_HI, spg_pkg::VEC_W'({$urandom, $urandom}));
        send_point(2, 9);
        send_point(16, 0);
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 6; phase++)
        begin
            write_reg(spg_pkg::CFG_CENTER, random_vec());
            write_reg(spg_pkg::CFG_SPAN_U, random_vec());
            write_reg(spg_pkg::CFG_SPAN_V, random_vec());
            case (phase)
                0: write_reg(spg_pkg::CFG_GRID, 7'd1);
                1: write_reg(spg_pkg::CFG_GRID, 7'd64);
                2: write_reg(spg_pkg::CFG_GRID, 7'd0);
                default: write_reg(spg_pkg::CFG_GRID,
                                   spg_pkg::VEC_W'($urandom_range(0, 127)));
            endcase
            write_reg(spg_pkg::CFG_BORDER, spg_pkg::VEC_W'($urandom_range(0, 7)));
            write_reg(spg_pkg::CFG_REVERSE, spg_pkg::VEC_W'($urandom_range(0, 1)));
            send_gaps = (phase != 2);
            ready_gaps = (phase != 3);
            repeat (90) send_point(random_index(), random_index());
        end
        send_gaps = 1'b1;
        ready_gaps = 1'b1;
    endtask

    // more items than the pipeline holds, so the input stalls during the hold
    task automatic test_backpressure();
        drain();
        send_gaps = 1'b0;
        @(posedge clk);
        ready_hold <= 300;
        repeat (120) send_point(random_index(), random_index());
        send_gaps = 1'b1;
    endtask

    task automatic test_sender_pause();
        repeat (10) send_point(random_index(), random_index());
        drain();
        repeat (10) send_point(random_index(), random_index());
    endtask

    initial
    begin
        int waited;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        row = '0;
        col = '0;
        out_ready = 1'b0;
        mismatches = 0;
        send_gaps = 1'b1;
        ready_gaps = 1'b1;
        ready_hold = 0;
        center_reg = '0;
        span_u_reg = '0;
        span_v_reg = '0;
        grid_reg = 7'd16;
        border_reg = '0;
        reverse_reg = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_directed();
        test_spare_index();
        test_random_phases();
        test_backpressure();
        test_sender_pause();

        in_valid <= 1'b0;
        waited = 0;
        while (pending_vertices.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (80) @(posedge clk);
        if (mismatches == 0 && pending_vertices.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: sphere_patch_grid_point_unit.f
+incdir+rtl
rtl/spg_pkg.sv
rtl/spg_front.sv
rtl/spg_queue.sv
rtl/spg_back.sv
rtl/sphere_patch_grid_point_unit.sv
tb/sv/sphere_patch_grid_point_unit_test.sv
